// ----- src/nearest_sample_rate_converter_defines.svh -----
// Assertion macros for the nearest sample rate converter.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef NEAREST_SAMPLE_RATE_CONVERTER_DEFINES_SVH
`define NEAREST_SAMPLE_RATE_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, skipped while reset is asserted.
`define NSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define NSRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define NSRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/nsrc_pkg.sv -----
// Shared types and constants of the nearest sample rate converter.
// No dependencies; imported by the phase unit and the top level.
package nsrc_pkg;

  localparam int FracBits = 9;
  localparam int PhaseW   = 40;
  localparam int IdxW     = 24;
  localparam int StepW    = 13;
  localparam int SampleW  = 16;
  localparam int CfgW     = 24;
  localparam int BurstW   = 7;

  localparam logic [StepW-1:0]  UnityStep  = 13'd512;
  localparam logic [StepW-1:0]  DoubleStep = 13'd1024;
  localparam logic [7:0]        Centre     = 8'd128;
  localparam logic [BurstW-1:0] MaxBurst   = 7'd64;

  // Configuration register indexes
  localparam logic [1:0] CfgStep  = 2'd0;
  localparam logic [1:0] CfgWide  = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SampleW-1:0] src_sample;
    logic               src_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      out_last;
  } out_item_t;

  // Result of the shared phase unit
  typedef struct packed {
    logic              fits;
    logic [PhaseW-1:0] phase_next;
  } phase_res_t;

endpackage

// ----- src/nsrc_phase_unit.sv -----
// Shared phase unit: compares the integer part of the phase with the source
// index and forms the advanced phase. Depends on nsrc_pkg.
module nsrc_phase_unit
  import nsrc_pkg::*;
(
  input  logic [PhaseW-1:0] phase_i,
  input  logic [StepW-1:0]  step_i,
  input  logic [IdxW-1:0]   src_idx_i,
  output phase_res_t        res_o
);

  logic [StepW-1:0] step_eff;

  // Ratio two runs at unity step
  assign step_eff = (step_i == DoubleStep) ? UnityStep : step_i;

  always_comb begin
    res_o.fits = phase_i[PhaseW-1:FracBits] <=
                 {{(PhaseW-FracBits-IdxW){1'b0}}, src_idx_i};
    res_o.phase_next = phase_i + {{(PhaseW-StepW){1'b0}}, step_eff};
  end

endmodule

// ----- src/nearest_sample_rate_converter.sv -----
// Top level of the nearest sample rate converter: sequencer, state and
// configuration registers. Depends on nsrc_pkg, nsrc_phase_unit and the defines header.
//
// Usage:
//   Source samples enter on in_valid_i / in_stall_o / in_data_i, converted
//   samples leave on out_valid_o / out_stall_i / out_data_o. Each request
//   carries a packed struct from nsrc_pkg.
//   Registers are written through cfg_we_i, cfg_index_i and cfg_data_i:
//   0 step_q9, 1 wide_samples, 2 out_count. The user must write them only
//   while the block is idle; the block itself does not enforce this.
//   An accepted source sample is checked against the phase in the cycle after
//   acceptance. Each output it produces passes a check through the shared
//   phase compare/add unit, then waits in the output register. A source
//   sample yields at most 64 outputs; in_stall_o is high while the block
//   works on it, also while the receiver stalls.
//   While out_stall_i is high the output register holds its request and the
//   sequencer waits.
//   Reset clears the phase, source index and output count and loads the
//   registers with step 512, 8-bit samples and a count of zero. After a
//   source sample marked last, the phase, index and count clear again.
`include "nearest_sample_rate_converter_defines.svh"

module nearest_sample_rate_converter
  import nsrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  state_e state_q, state_d;

  logic [StepW-1:0]  step_q;
  logic              wide_q;
  logic [IdxW-1:0]   count_q;

  logic [IdxW-1:0]   src_idx_q, src_idx_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [IdxW-1:0]   done_q, done_d;
  logic [BurstW-1:0] burst_q, burst_d;

  logic [SampleW-1:0] sample_q;
  logic               last_q;
  out_item_t          out_q, out_d;

  logic               accept;
  logic               go;
  logic [IdxW-1:0]    done_inc;
  logic [SampleW-1:0] conv;
  phase_res_t         pres;

  nsrc_phase_unit u_phase (
    .phase_i   (phase_q),
    .step_i    (step_q),
    .src_idx_i (src_idx_q),
    .res_o     (pres)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign done_inc = done_q + 24'd1;
  assign go       = (burst_q < MaxBurst) && (done_q < count_q) && pres.fits;

  // Recenter 8-bit samples around zero
  assign conv = wide_q ? in_data_i.src_sample
                       : ({8'h00, in_data_i.src_sample[7:0]} - {8'h00, Centre});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= UnityStep;
      wide_q  <= 1'b0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStep:  step_q  <= cfg_data_i[StepW-1:0];
        CfgWide:  wide_q  <= cfg_data_i[0];
        CfgCount: count_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      src_idx_q <= '0;
      phase_q   <= '0;
      done_q    <= '0;
      burst_q   <= '0;
    end else begin
      state_q   <= state_d;
      src_idx_q <= src_idx_d;
      phase_q   <= phase_d;
      done_q    <= done_d;
      burst_q   <= burst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= conv;
      last_q   <= in_data_i.src_last;
    end
    out_q <= out_d;
  end

  always_comb begin
    state_d   = state_q;
    src_idx_d = src_idx_q;
    phase_d   = phase_q;
    done_d    = done_q;
    burst_d   = burst_q;
    out_d     = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          burst_d = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go) begin
          out_d.out_sample = sample_q;
          out_d.out_last   = (done_inc == count_q);
          done_d  = done_inc;
          phase_d = pres.phase_next;
          burst_d = burst_q + 7'd1;
          state_d = ST_EMIT;
        end else begin
          // Advance to the next source sample, or clear after the last one
          if (last_q) begin
            src_idx_d = '0;
            phase_d   = '0;
            done_d    = '0;
          end else begin
            src_idx_d = src_idx_q + 24'd1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_data_o  = out_q;

  `NSRC_ASSERT(a_out_blocks_in, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input taken while output pending")
  `NSRC_ASSERT(a_burst_cap, clk_i, rst_ni, burst_q <= MaxBurst, "burst count above limit")
  `NSRC_ASSERT(a_accept_checks, clk_i, rst_ni, accept |=> (state_q == ST_CHECK && !out_valid_o), "accepted sample not checked")
  `NSRC_ASSERT(a_last_clears, clk_i, rst_ni, (state_q == ST_CHECK && !go && last_q) |=> (src_idx_q == '0 && phase_q == '0 && done_q == '0), "state not cleared after last sample")

endmodule

// ----- sim/tb_nearest_sample_rate_converter.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_sample_rate_converter: directed and random
// source sounds under many register settings. Depends on nsrc_pkg and the RTL.
module tb_nearest_sample_rate_converter;
  import nsrc_pkg::*;

  localparam int RandItems  = 480;
  localparam int WatchLimit = 3000;
  localparam int DrainCycles = 2 * 64 + 8;

  // Tracks the resampler state and holds the converted samples still owed.
  class resampler_scoreboard;
    logic [StepW-1:0]  step_reg;
    logic              wide_reg;
    logic [IdxW-1:0]   count_reg;
    logic [IdxW-1:0]   src_idx;
    logic [PhaseW-1:0] phase;
    logic [IdxW-1:0]   done_cnt;
    out_item_t         expected_out[$];
    int                mismatches;
    int                n_src;
    int                n_out;

    function new();
      step_reg   = UnityStep;
      wide_reg   = 1'b0;
      count_reg  = '0;
      src_idx    = '0;
      phase      = '0;
      done_cnt   = '0;
      mismatches = 0;
      n_src      = 0;
      n_out      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CfgW-1:0] d);
      case (idx)
        CfgStep:  step_reg = d[StepW-1:0];
        CfgWide:  wide_reg = d[0];
        CfgCount: count_reg = d;
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void note_source(in_item_t req);
      logic signed [SampleW-1:0] conv;
      logic [PhaseW-1:0]         eff_step;
      out_item_t                 o;
      int                        burst;
      burst = 0;
      n_src++;
      // recenter 8-bit samples, upper byte ignored
      conv = wide_reg ? req.src_sample
                      : $signed({8'h00, req.src_sample[7:0]} - {8'h00, Centre});
      eff_step = (step_reg == DoubleStep) ? PhaseW'(UnityStep) : PhaseW'(step_reg);
      while (burst < MaxBurst && done_cnt < count_reg &&
             (phase >> FracBits) <= PhaseW'(src_idx)) begin
        o.out_sample = conv;
        o.out_last   = (done_cnt == count_reg - 24'd1);
        expected_out.push_back(o);
        done_cnt = done_cnt + 24'd1;
        phase    = phase + eff_step;
        burst++;
      end
      src_idx = src_idx + 24'd1;
      if (req.src_last) begin
        src_idx  = '0;
        phase    = '0;
        done_cnt = '0;
      end
    endfunction

    task check_output(out_item_t got);
      out_item_t exp;
      n_out++;
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %h last %b", got.out_sample,
                                  got.out_last));
      end else begin
        exp = expected_out.pop_front();
        if (got.out_sample !== exp.out_sample)
          report_mismatch($sformatf("out_sample %h, want %h", got.out_sample,
                                    exp.out_sample));
        if (got.out_last !== exp.out_last)
          report_mismatch($sformatf("out_last %b, want %b", got.out_last, exp.out_last));
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [1:0]      cfg_index = CfgStep;
  logic [CfgW-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_item_t       out_data;

  logic            in_idle_en = 1'b0;
  logic            out_idle_en = 1'b0;
  int              stall_left = 0;
  int              idle_cycles = 0;
  int              n_settings = 0;
  resampler_scoreboard sb;

  nearest_sample_rate_converter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // Receiver stalls at random in bursts, which start only while out_idle_en is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_source(in_data);
      if (out_valid && !out_stall) sb.check_output(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Timeout: no request moved for %0d cycles", WatchLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request and hold it until accepted; may idle first.
  task automatic send_sample(logic [SampleW-1:0] sample, logic last);
    if (in_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.src_sample <= sample;
    in_data.src_last   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every owed sample, then let the block settle.
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_out.size() != 0);
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int sent;
    int len;
    bit broken;
    logic last;
    logic [StepW-1:0] step_pick;
    logic [CfgW-1:0]  count_pick;

    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: count zero, nothing comes out
    send_sample(16'h00AB, 1'b0);
    send_sample(16'h0001, 1'b1);
    settle_idle();
    n_settings++;

    // Ratio 2 acts as unity; upper byte ignored in 8-bit mode
    write_reg(CfgStep, CfgW'(DoubleStep));
    write_reg(CfgCount, 24'd4);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'hFF80, 1'b0);
    send_sample(16'h127F, 1'b1);
    settle_idle();
    n_settings++;

    // Step zero: burst cap on the first sample, held-back outputs on the next
    write_reg(CfgWide, 24'd1);
    write_reg(CfgStep, 24'd0);
    write_reg(CfgCount, 24'd70);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    settle_idle();
    n_settings++;

    // Largest step with the largest count
    write_reg(CfgStep, 24'd8191);
    write_reg(CfgCount, 24'hFFFFFF);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h5A5A, 1'b0);
    send_sample(16'hA5A5, 1'b1);
    settle_idle();
    n_settings++;

    // Step below eight in 8-bit mode
    write_reg(CfgWide, 24'd0);
    write_reg(CfgStep, 24'd3);
    write_reg(CfgCount, 24'd200);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h0080, 1'b1);
    settle_idle();
    n_settings++;

    // Upsample by two, last output marked
    write_reg(CfgStep, 24'd256);
    write_reg(CfgCount, 24'd6);
    send_sample(16'h0010, 1'b0);
    send_sample(16'h0020, 1'b0);
    send_sample(16'h0030, 1'b1);
    settle_idle();
    n_settings++;

    sent = 0;
    while (sent < RandItems) begin
      in_idle_en  = (sent < RandItems * 85 / 100) && ($urandom_range(0, 3) != 0);
      out_idle_en = (sent < RandItems * 85 / 100) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       step_pick = '0;
        1:       step_pick = StepW'($urandom_range(1, 7));
        2:       step_pick = DoubleStep;
        3:       step_pick = 13'd8191;
        4:       step_pick = $urandom_range(0, 1) ? 13'd4096 : 13'd8;
        5:       step_pick = StepW'($urandom_range(0, 8191));
        6:       step_pick = StepW'($urandom_range(8, 4096));
        default: step_pick = StepW'($urandom_range(128, 1024));
      endcase
      case ($urandom_range(0, 5))
        0:       count_pick = '0;
        1:       count_pick = 24'hFFFFFF;
        2:       count_pick = CfgW'($urandom_range(1, 400));
        3:       count_pick = CfgW'($urandom_range(1, 8));
        default: count_pick = CfgW'($urandom_range(1, 60));
      endcase
      write_reg(CfgStep, CfgW'(step_pick));
      write_reg(CfgWide, CfgW'($urandom_range(0, 1)));
      write_reg(CfgCount, count_pick);
      n_settings++;
      repeat ($urandom_range(1, 4)) begin
        len    = $urandom_range(1, 24);
        broken = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1) && !broken;
          if ($urandom_range(0, 11) == 0) last = 1'($urandom_range(0, 1));
          send_sample(SampleW'($urandom), last);
          sent++;
        end
      end
      settle_idle();
    end

    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    do @(posedge clk); while (sb.expected_out.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d source samples under %0d register settings,",
             sb.n_src, n_settings);
    $display("with %0d converted samples compared and %0d mismatches.",
             sb.n_out, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- nearest_sample_rate_converter.f -----
+incdir+src
src/nsrc_pkg.sv
src/nsrc_phase_unit.sv
src/nearest_sample_rate_converter.sv
sim/tb_nearest_sample_rate_converter.sv
